/* hw/rtl/wnrb_pkg.sv */
// Package for the wide-node ray/box hit mask block.
// Holds the mode codes, default parameters and the saturating slab-distance helper.
// No dependencies.
package wnrb_pkg;

  localparam int NodeCountDefault = 1024;
  localparam int SlotsDefault     = 8;
  localparam int FracBitsDefault  = 16;
  localparam int ValW             = 32;
  localparam int MaskW            = 8;

  typedef enum logic [1:0] {
    MODE_LOAD_RAY  = 2'd0,
    MODE_WRITE_BOX = 2'd1,
    MODE_TEST_NODE = 2'd2,
    MODE_NOP       = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [ValW-1:0] ox, oy, oz;
    logic signed [ValW-1:0] ix, iy, iz;
    logic signed [ValW-1:0] t_lo, t_hi;
  } ray_t;

  typedef struct packed {
    logic signed [ValW-1:0] lx, ly, lz;
    logic signed [ValW-1:0] hx, hy, hz;
  } box_t;

  // Saturate a product (already shifted) to 32 bits signed.
  function automatic logic signed [ValW-1:0] sat32(input logic signed [65:0] q);
    logic signed [65:0] lim_hi;
    logic signed [65:0] lim_lo;
    lim_hi = 66'sd2147483647;
    lim_lo = -66'sd2147483648;
    if (q > lim_hi) sat32 = 32'sh7fffffff;
    else if (q < lim_lo) sat32 = 32'sh80000000;
    else sat32 = q[ValW-1:0];
  endfunction

endpackage

/* hw/rtl/wnrb_lane.sv */
// One slot lane: two-stage slab test of one child box against the ray.
// Depends on wnrb_pkg.
module wnrb_lane #(
  parameter int FRAC_BITS = wnrb_pkg::FracBitsDefault
) (
  input  logic           clk,
  input  wnrb_pkg::ray_t ray,
  input  wnrb_pkg::box_t box,
  input  logic           en,
  output logic           hit
);
  logic signed [32:0] dn [3];
  logic signed [32:0] df [3];
  logic signed [31:0] inv [3];
  logic signed [65:0] pn [3];
  logic signed [65:0] pf [3];
  logic signed [31:0] tn [3];
  logic signed [31:0] tf [3];
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic signed [31:0] org [3];
  logic signed [31:0] tmin, tmax;

  always_comb begin
    inv = '{ray.ix, ray.iy, ray.iz};
    lo  = '{box.lx, box.ly, box.lz};
    hi  = '{box.hx, box.hy, box.hz};
    org = '{ray.ox, ray.oy, ray.oz};
    for (int a = 0; a < 3; a++) begin
      dn[a] = inv[a][31] ? (33'(hi[a]) - 33'(org[a])) : (33'(lo[a]) - 33'(org[a]));
      df[a] = inv[a][31] ? (33'(lo[a]) - 33'(org[a])) : (33'(hi[a]) - 33'(org[a]));
    end
  end

  // Stage 1: products registered.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        pn[a] <= 66'(dn[a]) * 66'(inv[a]);
        pf[a] <= 66'(df[a]) * 66'(inv[a]);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      tn[a] = wnrb_pkg::sat32(pn[a] >>> FRAC_BITS);
      tf[a] = wnrb_pkg::sat32(pf[a] >>> FRAC_BITS);
    end
    tmin = tn[0];
    tmax = tf[0];
    for (int a = 1; a < 3; a++) begin
      if (tn[a] > tmin) tmin = tn[a];
      if (tf[a] < tmax) tmax = tf[a];
    end
    hit = (tmin <= tmax) && (tmax >= ray.t_lo) && (tmin <= ray.t_hi);
  end
endmodule

/* hw/rtl/wnrb_slot_store.sv */
// Box memory and occupied bit for one slot across all nodes; registered read.
// Depends on wnrb_pkg.
module wnrb_slot_store #(
  parameter int NODE_COUNT = wnrb_pkg::NodeCountDefault,
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  wnrb_pkg::box_t wdata,
  input  logic           wvalid,
  input  logic [AW-1:0]  raddr,
  output wnrb_pkg::box_t rdata,
  output logic           rvalid
);
  wnrb_pkg::box_t mem [NODE_COUNT];
  logic           vld [NODE_COUNT];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
      vld[waddr] <= wvalid;
    end
    rdata  <= mem[raddr];
    rvalid <= vld[raddr];
  end
endmodule

/* hw/rtl/wide_node_ray_box_hit_mask.sv */
// Top level: ray register, per-slot box memories with occupied bits, slot lanes, mask merge.
// Depends on wnrb_pkg, wnrb_slot_store, wnrb_lane.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, mode..segment_end     | request in
//  out     | out_valid, out_stall, hit_mask            | request out
//
// A node test runs through box memory read, lane products, then compare and merge
// into hit_mask; out_valid rises together with hit_mask.
// in_stall is high while a test is in flight, so a new request waits until that test
// is through; other requests are accepted every cycle while nothing else stalls them.
// Reset (rst, synchronous) clears the ray, then a clearing pass walks every node and
// zeroes every box and occupied bit with in_stall high. A result held by out_stall
// keeps hit_mask steady and stalls further requests until it is taken.
module wide_node_ray_box_hit_mask #(
  parameter int NODE_COUNT = wnrb_pkg::NodeCountDefault,
  parameter int SLOTS      = wnrb_pkg::SlotsDefault,
  parameter int FRAC_BITS  = wnrb_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [9:0]  node_index,
  input  logic [2:0]  slot,
  input  logic        slot_valid,
  input  logic signed [31:0] x_first,
  input  logic signed [31:0] y_first,
  input  logic signed [31:0] z_first,
  input  logic signed [31:0] x_second,
  input  logic signed [31:0] y_second,
  input  logic signed [31:0] z_second,
  input  logic signed [31:0] segment_start,
  input  logic signed [31:0] segment_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  hit_mask
);
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  wnrb_pkg::ray_t ray;
  wnrb_pkg::box_t wbox;
  wnrb_pkg::box_t wr_box;
  logic [SLOTS-1:0] vm1, vm2, lane_hit;
  logic [1:0] busy;   // s1: mem read, s2: product
  logic       inr1, inr2;
  logic       acc;
  logic [AW-1:0] addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] clr_addr;
  logic       clearing;
  logic       wr_valid;
  logic       node_ok;
  wnrb_pkg::mode_t md;

  assign md       = wnrb_pkg::mode_t'(mode);
  // A waiting result only blocks new requests while it is stalled.
  assign in_stall = clearing | busy[0] | busy[1] | (out_valid & out_stall);
  assign acc      = in_valid & ~in_stall;
  assign addr     = AW'(node_index);
  assign node_ok  = 32'(node_index) < NODE_COUNT;
  assign wbox     = '{x_first, y_first, z_first, x_second, y_second, z_second};

  // Write port: clearing pass walks every node, otherwise the box write request.
  assign wr_addr  = clearing ? clr_addr : addr;
  assign wr_box   = clearing ? '0 : wbox;
  assign wr_valid = clearing ? 1'b0 : slot_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(NODE_COUNT - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ray <= '0;
    end else if (acc && md == wnrb_pkg::MODE_LOAD_RAY) begin
      ray <= '{x_first, y_first, z_first, x_second, y_second, z_second,
               segment_start, segment_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= '0;
      out_valid <= 1'b0;
    end else begin
      busy[0] <= acc && md == wnrb_pkg::MODE_TEST_NODE;
      busy[1] <= busy[0];
      if (busy[1]) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Occupied bits come out of the stores with the boxes and ride along to the merge.
  always_ff @(posedge clk) begin
    if (acc) begin
      inr1 <= node_ok;
    end
    inr2 <= inr1;
    vm2  <= vm1;
    if (busy[1]) begin
      hit_mask <= 8'(inr2 ? (lane_hit & vm2) : '0);
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_lane
    wnrb_pkg::box_t rb;
    logic wr_en;
    assign wr_en = clearing |
                   (acc && md == wnrb_pkg::MODE_WRITE_BOX && node_ok && 32'(slot) == s);
    wnrb_slot_store #(.NODE_COUNT(NODE_COUNT)) u_store (
      .clk(clk),
      .we(wr_en),
      .waddr(wr_addr), .wdata(wr_box), .wvalid(wr_valid),
      .raddr(addr), .rdata(rb), .rvalid(vm1[s])
    );
    wnrb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .ray(ray), .box(rb), .en(busy[0]), .hit(lane_hit[s])
    );
  end
endmodule

/* test/hit_mask_checker.sv */
`timescale 1ns / 100ps
// Checker for wide_node_ray_box_hit_mask: mirrors ray, boxes and valid masks,
// predicts the hit mask of each node test and compares. Depends on wnrb_pkg.
module hit_mask_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [9:0]         node_index,
  input  logic [2:0]         slot,
  input  logic               slot_valid,
  input  logic signed [31:0] x_first,
  input  logic signed [31:0] y_first,
  input  logic signed [31:0] z_first,
  input  logic signed [31:0] x_second,
  input  logic signed [31:0] y_second,
  input  logic signed [31:0] z_second,
  input  logic signed [31:0] segment_start,
  input  logic signed [31:0] segment_end,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         hit_mask,
  output int                 fail_count,
  output int                 pending
);
  localparam int QDepth = 16;

  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_inv [3];
  logic signed [31:0] t_near_bound, t_far_bound;
  logic signed [31:0] lo_corner [bit [14:0]];
  logic signed [31:0] hi_corner [bit [14:0]];
  logic [7:0]         occupied [1024];
  logic [7:0]         expected_masks [QDepth];
  int                 wr_ptr = 0;
  int                 rd_ptr = 0;

  assign pending = wr_ptr - rd_ptr;

  function automatic logic signed [31:0] plane_dist(logic signed [31:0] plane,
      logic signed [31:0] org, logic signed [31:0] inv);
    logic signed [65:0] diff;
    logic signed [65:0] prod;
    diff = 66'(plane) - 66'(org);
    prod = (diff * 66'(inv)) >>> 16;
    if (prod > 66'sd2147483647) return 32'sh7fffffff;
    if (prod < -66'sd2147483648) return 32'sh80000000;
    return prod[31:0];
  endfunction

  function automatic logic [7:0] node_hits(logic [9:0] node);
    logic [7:0] m;
    logic signed [31:0] enter, leave, tn, tf, lo, hi;
    bit [14:0] idx;
    m = 0;
    for (int s = 0; s < 8; s++) begin
      enter = 0;
      leave = 0;
      for (int a = 0; a < 3; a++) begin
        idx = 15'(({node, 3'(s)} * 3) + a);
        lo = lo_corner.exists(idx) ? lo_corner[idx] : 32'sd0;
        hi = hi_corner.exists(idx) ? hi_corner[idx] : 32'sd0;
        tn = plane_dist(ray_inv[a] < 0 ? hi : lo, ray_org[a], ray_inv[a]);
        tf = plane_dist(ray_inv[a] < 0 ? lo : hi, ray_org[a], ray_inv[a]);
        if (a == 0 || tn > enter) enter = tn;
        if (a == 0 || tf < leave) leave = tf;
      end
      if (enter <= leave && leave >= t_near_bound && enter <= t_far_bound) m[s] = 1'b1;
    end
    return m & occupied[node];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        ray_org[a] = 0;
        ray_inv[a] = 0;
      end
      t_near_bound = 0;
      t_far_bound = 0;
      for (int n = 0; n < 1024; n++) occupied[n] = 0;
      lo_corner.delete();
      hi_corner.delete();
      wr_ptr = 0;
      rd_ptr = 0;
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        unique case (wnrb_pkg::mode_t'(mode))
          wnrb_pkg::MODE_LOAD_RAY: begin
            ray_org[0] = x_first;  ray_org[1] = y_first;  ray_org[2] = z_first;
            ray_inv[0] = x_second; ray_inv[1] = y_second; ray_inv[2] = z_second;
            t_near_bound = segment_start;
            t_far_bound = segment_end;
          end
          wnrb_pkg::MODE_WRITE_BOX: begin
            lo_corner[15'({node_index, slot} * 3)]     = x_first;
            lo_corner[15'({node_index, slot} * 3 + 1)] = y_first;
            lo_corner[15'({node_index, slot} * 3 + 2)] = z_first;
            hi_corner[15'({node_index, slot} * 3)]     = x_second;
            hi_corner[15'({node_index, slot} * 3 + 1)] = y_second;
            hi_corner[15'({node_index, slot} * 3 + 2)] = z_second;
            occupied[node_index][slot] = slot_valid;
          end
          wnrb_pkg::MODE_TEST_NODE: begin
            expected_masks[wr_ptr % QDepth] = node_hits(node_index);
            wr_ptr = wr_ptr + 1;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (wr_ptr == rd_ptr) begin
          $display("%0t: unexpected hit_mask %h", $time, hit_mask);
          fail_count <= fail_count + 1;
        end else begin
          if (hit_mask !== expected_masks[rd_ptr % QDepth]) begin
            $display("%0t: hit_mask expected %h actual %h", $time,
                     expected_masks[rd_ptr % QDepth], hit_mask);
            fail_count <= fail_count + 1;
          end
          rd_ptr = rd_ptr + 1;
        end
      end
    end
  end
endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the hit-mask testbench: clock, reset, request stimulus and verdict.
// Depends on wnrb_pkg, hit_mask_checker and the block itself.
module testbench;
  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] mode = wnrb_pkg::MODE_NOP;
  logic [9:0] node_index = 0;
  logic [2:0] slot = 0;
  logic slot_valid = 0;
  logic signed [31:0] x_first = 0, y_first = 0, z_first = 0;
  logic signed [31:0] x_second = 0, y_second = 0, z_second = 0;
  logic signed [31:0] segment_start = 0, segment_end = 0;
  logic [7:0] hit_mask;
  int fail_count, pending;
  int idle_cycles = 0;
  bit hold_off = 0;

  always #10 clk = ~clk;

  wide_node_ray_box_hit_mask uut (.*);
  hit_mask_checker check (.*);

  // Watchdog: cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 9) != 0);
    else out_stall <= 0;
  end
  initial begin
    wait (!rst);
    // past the clearing pass, into the random traffic
    repeat (wnrb_pkg::NodeCountDefault + 200) @(posedge clk);
    hold_off = 1;
    repeat (150) @(posedge clk);
    hold_off = 0;
  end

  // Pick a corner value: extremes, small, or full random.
  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4, 5: return $signed($urandom_range(0, 32'h00140000)) - 32'sh000a0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [1:0] m, logic [9:0] n, logic [2:0] s, logic v,
      logic signed [31:0] a0, a1, a2, b0, b1, b2, t0, t1);
    int gap;
    mode <= m; node_index <= n; slot <= s; slot_valid <= v;
    x_first <= a0; y_first <= a1; z_first <= a2;
    x_second <= b0; y_second <= b1; z_second <= b2;
    segment_start <= t0; segment_end <= t1;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
          ($urandom_range(0, 30) == 0) ? $urandom_range(10, 40) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic rand_box(logic [9:0] n, logic [2:0] s);
    send(wnrb_pkg::MODE_WRITE_BOX, n, s, $urandom_range(0, 3) != 0, pick_val(), pick_val(),
         pick_val(), pick_val(), pick_val(), pick_val(), $urandom, $urandom);
  endtask

  initial begin
    logic [9:0] n;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty node, zero ray, extremes, swapped bounds, zero inverse.
    send(wnrb_pkg::MODE_TEST_NODE, 10'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(wnrb_pkg::MODE_WRITE_BOX, 10'd1023, 3'd7, 1, -32'sh10000, -32'sh10000,
         -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0);
    send(wnrb_pkg::MODE_WRITE_BOX, 10'd1023, 3'd0, 1, 32'sh80000000, 32'sh80000000,
         32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    send(wnrb_pkg::MODE_WRITE_BOX, 10'd1023, 3'd1, 1, 32'sh20000, 32'sh20000, 32'sh20000,
         -32'sh20000, -32'sh20000, -32'sh20000, 0, 0);
    send(wnrb_pkg::MODE_WRITE_BOX, 10'd1023, 3'd2, 0, -32'sh10000, -32'sh10000,
         -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0);
    send(wnrb_pkg::MODE_TEST_NODE, 10'd1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(wnrb_pkg::MODE_LOAD_RAY, 0, 0, 0, -32'sh50000, 0, 0, 32'sh10000, 32'sh7fffffff,
         32'sh7fffffff, 0, 32'sh7fffffff);
    send(wnrb_pkg::MODE_TEST_NODE, 10'd1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(wnrb_pkg::MODE_LOAD_RAY, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000,
         32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000);
    send(wnrb_pkg::MODE_TEST_NODE, 10'd1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(wnrb_pkg::MODE_NOP, 10'h2aa, 3'd5, 1, 1, 1, 1, 1, 1, 1, 1, 1);
    // Random: fill a few nodes, then load rays and test, with noise mixed in.
    for (int i = 0; i < 540; i++) begin
      n = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3)) << 8 |
          10'($urandom_range(0, 7)) | 10'h0f0;
      case ($urandom_range(0, 9))
        0, 1, 2: rand_box(n, 3'($urandom));
        3: send(wnrb_pkg::MODE_LOAD_RAY, 0, 0, 0, pick_val(), pick_val(), pick_val(),
                ($urandom_range(0, 4) == 0) ? pick_val() :
                  $signed($urandom_range(0, 32'h40000)) - 32'sh20000,
                ($urandom_range(0, 4) == 0) ? pick_val() :
                  $signed($urandom_range(0, 32'h40000)) - 32'sh20000,
                ($urandom_range(0, 4) == 0) ? pick_val() :
                  $signed($urandom_range(0, 32'h40000)) - 32'sh20000,
                pick_val(), pick_val());
        9: send(wnrb_pkg::MODE_NOP, 10'($urandom), 3'($urandom), 1'($urandom), $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: send(wnrb_pkg::MODE_TEST_NODE, n, 3'($urandom), 1'($urandom), $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
      endcase
    end
    in_valid <= 0;
    mode <= wnrb_pkg::MODE_NOP;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
